FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands for the rtl that checks itself
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define CHP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CHP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/chp_pkg.sv
// ----------------------------------------------------------------------------
// chp_pkg
// shared types, codes and the divide-by-twenty digit step of the histogram
// ----------------------------------------------------------------------------
`default_nettype none

package chp_pkg;

    localparam int OUT_COUNT_W  = 24;
    localparam int OUT_HEIGHT_W = 20;
    localparam int SAMPLE_W     = 8;
    localparam int DIGIT_W      = 8;
    localparam int BAR_DIVISOR  = 20;
    localparam int REM_W        = 5;

    localparam logic [1:0] REQ_ACCUMULATE = 2'd0;
    localparam logic [1:0] REQ_READ       = 2'd1;
    localparam logic [1:0] REQ_CLEAR      = 2'd2;

    localparam logic [1:0] CHAN_RED   = 2'd0;
    localparam logic [1:0] CHAN_GREEN = 2'd1;
    localparam logic [1:0] CHAN_BLUE  = 2'd2;

    typedef struct packed {
        logic [1:0]          req_type;
        logic [SAMPLE_W-1:0] red;
        logic [SAMPLE_W-1:0] green;
        logic [SAMPLE_W-1:0] blue;
        logic [SAMPLE_W-1:0] bin_index;
    } req_t;

    typedef struct packed {
        logic [OUT_COUNT_W-1:0]  bin_count;
        logic [OUT_HEIGHT_W-1:0] bar_height;
        logic [OUT_COUNT_W-1:0]  peak_count;
        logic [OUT_HEIGHT_W-1:0] chart_height;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic clr_init;
        logic clr_step;
        logic acc_write;
        logic div_load;
        logic div_step;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] req_type;
        logic       acc_ok;
        logic       clr_last;
        logic       div_last;
    } stat_t;

    typedef struct packed {
        logic [REM_W-1:0]   rem;
        logic [DIGIT_W-1:0] quo;
    } div_digit_t;

    // eight restoring steps of division by twenty, remainder stays below twenty
    function automatic div_digit_t div_digit(input logic [REM_W-1:0] rem_in,
                                             input logic [DIGIT_W-1:0] digit);
        logic [REM_W:0] r;
        div_digit_t     res;
        r       = {1'b0, rem_in};
        res.quo = '0;
        for (int i = 0; i < DIGIT_W; i++) begin
            r = {r[REM_W-1:0], digit[DIGIT_W-1-i]};
            if (r >= (REM_W+1)'(BAR_DIVISOR)) begin
                res.quo[DIGIT_W-1-i] = 1'b1;
                r = r - (REM_W+1)'(BAR_DIVISOR);
            end
        end
        res.rem = r[REM_W-1:0];
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/channel_histogram_with_peak.sv
// ----------------------------------------------------------------------------
// channel_histogram_with_peak
// per-channel pixel histogram with peak tracking and bar height readout
// ----------------------------------------------------------------------------
//
//  channel   handshake               payload           direction
//  -------   ---------------------   ---------------   ---------
//  request   start / busy            req (req_t)       in
//  result    result_valid strobe     result (result_t) out
//  config    cfg_valid / cfg_ready   cfg_data [1:0]    in
//
//  accumulate: a registered read of the bin memory, then the write-back;
//    read: the registered read, a load, then the byte-serial divide by
//    twenty and a done state; clear: a sweep over all BINS entries;
//    an ignored request is taken and changes nothing
//  reset starts a clearing pass over the bin memory; busy is
//    high until it ends, config writes wait for it as well
//  the receiver cannot stall: a result is shown for one cycle only
//
`default_nettype none

module channel_histogram_with_peak #(
    parameter int BINS       = 256,
    parameter int COUNT_BITS = 24
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // request transaction
    input  wire logic              start,
    output logic                   busy,
    input  wire chp_pkg::req_t     req,
    // result transaction
    output logic                   result_valid,
    output chp_pkg::result_t       result,
    // channel select register
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_data
);
    import chp_pkg::*;

`include "assert_macros.svh"

    cmd_t  cmd;
    stat_t stat;
    logic  cfg_we;

    // register writes land only while no request is in flight or being taken
    assign cfg_ready = !busy && !start;
    assign cfg_we    = cfg_valid && cfg_ready;

    // sequencing of clear sweep, accumulate and read
    chp_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .stat         (stat),
        .cmd          (cmd),
        .busy         (busy),
        .result_valid (result_valid)
    );

    // bin memory, peak, dividers
    chp_datapath #(
        .BINS       (BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .stat     (stat),
        .result   (result)
    );

    // a result strobe never repeats on the next cycle
    `CHP_ASSERT_NEXT(a_strobe_single, clk, rst_n, result_valid, !result_valid, "result repeated")

    // a clear transaction always starts a sweep
    `CHP_ASSERT_NEXT(a_clear_busy, clk, rst_n, start && !busy && (req.req_type == REQ_CLEAR),
                     busy && cmd.clr_step, "clear did not start sweep")

    // a read transaction shows no result in the following cycle
    `CHP_ASSERT_NEXT(a_read_latency, clk, rst_n, start && !busy && (req.req_type == REQ_READ),
                     !result_valid && cmd.div_load, "read result too early")

    // the bin memory is never written while a request is taken
    `CHP_ASSERT_NOW(a_no_write_on_accept, clk, rst_n, cmd.accept,
                    !cmd.clr_step && !cmd.acc_write, "write during accept")

endmodule

`default_nettype wire

FILE: hdl/chp_datapath.sv
// ----------------------------------------------------------------------------
// chp_datapath
// bin memory, peak register, clear sweep and the two divide-by-twenty units
// ----------------------------------------------------------------------------
`default_nettype none

module chp_datapath #(
    parameter int BINS       = 256,
    parameter int COUNT_BITS = 24
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire chp_pkg::req_t    req,
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_data,
    input  wire chp_pkg::cmd_t    cmd,
    output chp_pkg::stat_t        stat,
    output chp_pkg::result_t      result
);
    import chp_pkg::*;

    localparam int IDX_W      = $clog2(BINS);
    localparam int DIV_CYCLES = (COUNT_BITS + DIGIT_W - 1) / DIGIT_W;
    localparam int DIV_W      = DIV_CYCLES * DIGIT_W;
    localparam int DCNT_W     = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [COUNT_BITS-1:0] bin_mem [BINS];

    logic [1:0]            chan_sel_reg, chan_sel_next;
    logic [IDX_W-1:0]      ptr_reg, ptr_next;
    logic [COUNT_BITS-1:0] peak_reg, peak_next;
    logic [IDX_W-1:0]      acc_addr_reg;
    logic                  rd_ok_reg;
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic [COUNT_BITS-1:0] cnt_bin_reg;
    logic [DIV_W-1:0]      bin_div_reg, peak_div_reg;
    logic [DIV_W-1:0]      bin_quo_reg, peak_quo_reg;
    logic [REM_W-1:0]      bin_rem_reg, peak_rem_reg;
    logic [DCNT_W-1:0]     div_cnt_reg, div_cnt_next;

    logic [SAMPLE_W-1:0]   sample;
    logic                  chan_ok;
    logic [IDX_W-1:0]      rd_addr;
    logic [IDX_W-1:0]      wr_addr;
    logic [COUNT_BITS-1:0] wr_data;
    logic                  mem_we;
    logic [COUNT_BITS-1:0] inc_count;
    logic [COUNT_BITS-1:0] load_count;
    div_digit_t            bin_step, peak_step;

    // channel pick
    always_comb
    begin
        chan_ok = 1'b1;
        unique case (chan_sel_reg)
            CHAN_RED:   sample = req.red;
            CHAN_GREEN: sample = req.green;
            CHAN_BLUE:  sample = req.blue;
            default:
            begin
                sample  = req.red;
                chan_ok = 1'b0;
            end
        endcase
    end

    assign stat.req_type = req.req_type;
    assign stat.acc_ok   = chan_ok && (32'(sample) < 32'(BINS));
    assign stat.clr_last = (ptr_reg == IDX_W'(BINS - 1));
    assign stat.div_last = (div_cnt_reg == DCNT_W'(DIV_CYCLES - 1));

    assign rd_addr = (req.req_type == REQ_READ) ? IDX_W'(req.bin_index) : IDX_W'(sample);

    // saturating increment of the bin just read
    assign inc_count = (rd_data_reg != COUNT_MAX) ? rd_data_reg + 1'b1 : rd_data_reg;

    assign mem_we  = cmd.clr_step || cmd.acc_write;
    assign wr_addr = cmd.clr_step ? ptr_reg : acc_addr_reg;
    assign wr_data = cmd.clr_step ? '0 : inc_count;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bin_mem[wr_addr] <= wr_data;
        end
        if (cmd.accept)
        begin
            rd_data_reg <= bin_mem[rd_addr];
        end
    end

    always_comb
    begin
        chan_sel_next = cfg_we ? cfg_data : chan_sel_reg;

        ptr_next = ptr_reg;
        if (cmd.clr_init)
        begin
            ptr_next = '0;
        end
        else if (cmd.clr_step)
        begin
            ptr_next = ptr_reg + 1'b1;
        end

        peak_next = peak_reg;
        if (cmd.clr_init)
        begin
            peak_next = '0;
        end
        else if (cmd.acc_write && (inc_count > peak_reg))
        begin
            peak_next = inc_count;
        end

        div_cnt_next = div_cnt_reg;
        if (cmd.div_load)
        begin
            div_cnt_next = '0;
        end
        else if (cmd.div_step)
        begin
            div_cnt_next = div_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_sel_reg <= CHAN_RED;
            ptr_reg      <= '0;
            peak_reg     <= '0;
            div_cnt_reg  <= '0;
        end
        else
        begin
            chan_sel_reg <= chan_sel_next;
            ptr_reg      <= ptr_next;
            peak_reg     <= peak_next;
            div_cnt_reg  <= div_cnt_next;
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            acc_addr_reg <= IDX_W'(sample);
            rd_ok_reg    <= (32'(req.bin_index) < 32'(BINS));
        end
    end

    // digit-serial divide by twenty, one byte of each dividend per cycle
    assign load_count = rd_ok_reg ? rd_data_reg : '0;
    assign bin_step   = div_digit(bin_rem_reg, bin_div_reg[DIV_W-1 -: DIGIT_W]);
    assign peak_step  = div_digit(peak_rem_reg, peak_div_reg[DIV_W-1 -: DIGIT_W]);

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            cnt_bin_reg  <= load_count;
            bin_div_reg  <= DIV_W'(load_count);
            peak_div_reg <= DIV_W'(peak_reg);
            bin_rem_reg  <= '0;
            peak_rem_reg <= '0;
            bin_quo_reg  <= '0;
            peak_quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            bin_div_reg  <= bin_div_reg << DIGIT_W;
            peak_div_reg <= peak_div_reg << DIGIT_W;
            bin_rem_reg  <= bin_step.rem;
            peak_rem_reg <= peak_step.rem;
            bin_quo_reg  <= (bin_quo_reg << DIGIT_W) | DIV_W'(bin_step.quo);
            peak_quo_reg <= (peak_quo_reg << DIGIT_W) | DIV_W'(peak_step.quo);
        end
    end

    assign result.bin_count    = OUT_COUNT_W'(cnt_bin_reg);
    assign result.bar_height   = OUT_HEIGHT_W'(bin_quo_reg);
    assign result.peak_count   = OUT_COUNT_W'(peak_reg);
    assign result.chart_height = OUT_HEIGHT_W'(peak_quo_reg);

endmodule

`default_nettype wire

FILE: hdl/chp_ctrl.sv
// ----------------------------------------------------------------------------
// chp_ctrl
// request sequencer: clear sweep, accumulate, read with division
// ----------------------------------------------------------------------------
`default_nettype none

module chp_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire chp_pkg::stat_t  stat,
    output chp_pkg::cmd_t        cmd,
    output logic                 busy,
    output logic                 result_valid
);
    import chp_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_ACC   = 3'd2;
    localparam logic [2:0] ST_LOAD  = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    unique case (stat.req_type)
                        REQ_ACCUMULATE:
                        begin
                            if (stat.acc_ok)
                            begin
                                state_next = ST_ACC;
                            end
                        end
                        REQ_READ:  state_next = ST_LOAD;
                        REQ_CLEAR:
                        begin
                            cmd.clr_init = 1'b1;
                            state_next   = ST_CLEAR;
                        end
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ACC:
            begin
                cmd.acc_write = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = (state_reg == ST_DONE);

endmodule

`default_nettype wire
